// ===== hw/rtl/fsar_pkg.sv =====
// fsar_pkg: types and constants of the framed sender with ack retry
// used by framed_sender_with_ack_retry_core and its testbench, no dependencies
`default_nettype none

package fsar_pkg;

  localparam int FUNC_W    = 2;
  localparam int INDEX_W   = 5;
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 6;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_RX    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEND,
    ST_DLV
  } state_e;

  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b1;

  localparam logic [BYTE_W-1:0] BYTE_STX = 8'h02;
  localparam logic [BYTE_W-1:0] BYTE_ETX = 8'h03;
  localparam logic [BYTE_W-1:0] BYTE_ACK = 8'h06;
  localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hff;

  localparam logic [LEN_W-1:0]  RESET_LENGTH  = 6'd3;
  localparam logic [BYTE_W-1:0] RESET_TIMEOUT = 8'd10;

  localparam logic         KIND_BYTE      = 1'b0;
  localparam logic         KIND_DELIVERED = 1'b1;

endpackage

`default_nettype wire

// ===== hw/rtl/framed_sender_with_ack_retry_core.sv =====
// framed_sender_with_ack_retry_core: stop-and-wait frame sender, stx/etx framing,
// xor checksum, ack wait with tick timeout and resend
// depends on fsar_pkg and fsar_ram
//
// channel  | signals                                        | dir | handshake
// command  | start_i func_i index_i value_i / busy_o        | in  | start_i & !busy_o
// result   | res_valid_o kind_o tx_byte_o last_o attempt_o  | out | one-cycle strobe
// config   | cfg_valid_i cfg_index_i cfg_data_i / cfg_ready_o | in | valid & ready
//
// load, tick without resend and received byte words leave the core idle
// a frame goes out one byte a cycle from the byte counter, then a delivered word
// if an ack was latched before start; payload ram is read one byte ahead
// a delivered word from tick or received byte leaves in the cycle after acceptance
// async active-low reset clears control state; the payload ram is not cleared
// results cannot be stalled
`default_nettype none

module framed_sender_with_ack_retry_core #(
  parameter int MaxPayload = 32
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  output logic                                      busy_o,
  input  wire logic [fsar_pkg::FUNC_W-1:0]          func_i,
  input  wire logic [fsar_pkg::INDEX_W-1:0]         index_i,
  input  wire logic [fsar_pkg::BYTE_W-1:0]          value_i,
  output logic                                      res_valid_o,
  output logic                                      kind_o,
  output logic      [fsar_pkg::BYTE_W-1:0]          tx_byte_o,
  output logic                                      last_o,
  output logic      [fsar_pkg::BYTE_W-1:0]          attempt_o,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [fsar_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [fsar_pkg::BYTE_W-1:0]          cfg_data_i
);

  import fsar_pkg::*;

  localparam int AddrW = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;
  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MaxPayload);

  state_e state_q, state_d;

  logic              waiting_q, waiting_d;
  logic [BYTE_W-1:0] timer_q, timer_d;
  logic [BYTE_W-1:0] rx_q, rx_d;
  logic [BYTE_W-1:0] attempt_q, attempt_d;
  logic [LEN_W-1:0]  length_q, length_d;
  logic [BYTE_W-1:0] timeout_q, timeout_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic [BYTE_W-1:0] chk_q, chk_d;
  logic              from_start_q, from_start_d;

  logic              valid_q, valid_d;
  logic              kind_q, kind_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic              last_q, last_d;
  logic [BYTE_W-1:0] att_out_q, att_out_d;

  logic              accept;
  func_e             func;
  logic [LEN_W-1:0]  len_c;
  logic [LEN_W-1:0]  last_pos;
  logic [BYTE_W-1:0] limit;
  logic [BYTE_W-1:0] timer_inc;
  logic              start_go;
  logic              resend_go;
  logic              send_go;
  logic              tick_ack;
  logic              rx_ack;
  logic              ack_after;

  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic              ram_re;
  logic [AddrW-1:0]  ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  assign busy_o      = (state_q != ST_IDLE);
  assign accept      = start_i && !busy_o;
  assign func        = func_e'(func_i);
  assign cfg_ready_o = 1'b1;

  assign len_c     = (length_q > MaxLen) ? MaxLen : length_q;
  assign last_pos  = len_c + LEN_W'(3);
  assign limit     = (timeout_q == '0) ? BYTE_W'(1) : timeout_q;
  assign timer_inc = (timer_q == BYTE_MAX) ? BYTE_MAX : timer_q + BYTE_W'(1);

  assign start_go  = accept && (func == FUNC_START) && !waiting_q;
  assign tick_ack  = accept && (func == FUNC_TICK) && waiting_q && (rx_q == BYTE_ACK);
  assign resend_go = accept && (func == FUNC_TICK) && waiting_q && (rx_q != BYTE_ACK)
                     && (timer_inc >= limit);
  assign send_go   = start_go || resend_go;
  assign rx_ack    = accept && (func == FUNC_RX) && waiting_q && (value_i == BYTE_ACK);
  assign ack_after = from_start_q && (rx_q == BYTE_ACK);

  assign ram_we    = accept && (func == FUNC_LOAD) && (int'(index_i) < MaxPayload);
  assign ram_waddr = AddrW'(index_i);

  fsar_ram #(
    .Width(BYTE_W),
    .Depth(MaxPayload)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(value_i),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (send_go) begin
          state_d = ST_SEND;
        end
      end
      ST_SEND: begin
        if (cnt_q == last_pos) begin
          state_d = ack_after ? ST_DLV : ST_IDLE;
        end
      end
      ST_DLV: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // datapath and result word
  always_comb begin
    waiting_d    = waiting_q;
    timer_d      = timer_q;
    rx_d         = rx_q;
    attempt_d    = attempt_q;
    length_d     = length_q;
    timeout_d    = timeout_q;
    cnt_d        = cnt_q;
    chk_d        = chk_q;
    from_start_d = from_start_q;
    valid_d      = 1'b0;
    kind_d       = KIND_BYTE;
    byte_d       = '0;
    last_d       = 1'b0;
    att_out_d    = attempt_q;
    ram_re       = 1'b0;
    ram_raddr    = AddrW'(cnt_q - LEN_W'(1));

    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_LENGTH:  length_d  = cfg_data_i[LEN_W-1:0];
        CFG_TIMEOUT: timeout_d = cfg_data_i;
        default:     ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (accept && (func == FUNC_TICK) && waiting_q) begin
          timer_d = timer_inc;
        end
        if (accept && (func == FUNC_RX)) begin
          rx_d = value_i;
        end
        if (send_go) begin
          attempt_d    = (attempt_q == BYTE_MAX) ? BYTE_MAX : attempt_q + BYTE_W'(1);
          cnt_d        = '0;
          chk_d        = '0;
          timer_d      = '0;
          waiting_d    = 1'b1;
          from_start_d = start_go;
        end
        if (tick_ack || rx_ack) begin
          rx_d      = '0;
          waiting_d = 1'b0;
          valid_d   = 1'b1;
          kind_d    = KIND_DELIVERED;
          last_d    = 1'b1;
        end
      end
      ST_SEND: begin
        valid_d = 1'b1;
        cnt_d   = cnt_q + LEN_W'(1);
        ram_re  = (cnt_q != '0) && ((cnt_q - LEN_W'(1)) < len_c);
        if (cnt_q == '0) begin
          byte_d = BYTE_STX;
        end else if (cnt_q == LEN_W'(1)) begin
          byte_d = BYTE_W'(len_c);
        end else if (cnt_q < len_c + LEN_W'(2)) begin
          byte_d = ram_rdata;
          chk_d  = chk_q ^ ram_rdata;
        end else if (cnt_q < last_pos) begin
          byte_d = chk_q;
        end else begin
          byte_d = BYTE_ETX;
          last_d = !ack_after;
        end
      end
      ST_DLV: begin
        rx_d      = '0;
        waiting_d = 1'b0;
        valid_d   = 1'b1;
        kind_d    = KIND_DELIVERED;
        last_d    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      waiting_q    <= 1'b0;
      timer_q      <= '0;
      rx_q         <= '0;
      attempt_q    <= '0;
      length_q     <= RESET_LENGTH;
      timeout_q    <= RESET_TIMEOUT;
      cnt_q        <= '0;
      from_start_q <= 1'b0;
      valid_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      waiting_q    <= waiting_d;
      timer_q      <= timer_d;
      rx_q         <= rx_d;
      attempt_q    <= attempt_d;
      length_q     <= length_d;
      timeout_q    <= timeout_d;
      cnt_q        <= cnt_d;
      from_start_q <= from_start_d;
      valid_q      <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_q     <= chk_d;
    kind_q    <= kind_d;
    byte_q    <= byte_d;
    last_q    <= last_d;
    att_out_q <= att_out_d;
  end

  assign res_valid_o = valid_q;
  assign kind_o      = kind_q;
  assign tx_byte_o   = byte_q;
  assign last_o      = last_q;
  assign attempt_o   = att_out_q;

  a_deliver_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (kind_o == KIND_DELIVERED) |-> last_o && !waiting_q)
    else $error("delivered word not last or wait still armed");

  a_send_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEND) |-> waiting_q)
    else $error("frame in flight without ack wait armed");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_go |=> busy_o && (timer_q == '0) && (cnt_q == '0))
    else $error("start did not begin a frame");

  a_send_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEND) |=> res_valid_o && (kind_o == KIND_BYTE))
    else $error("send cycle gave no frame byte");

  a_idle_dlv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DLV) |=> (state_q == ST_IDLE) && (rx_q == '0))
    else $error("delivered state did not clear latch");

endmodule

`default_nettype wire

// ===== hw/rtl/fsar_ram.sv =====
// fsar_ram: generic single write port ram with registered read
// no dependencies
`default_nettype none

module fsar_ram #(
  parameter int Width = 8,
  parameter int Depth = 32,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_framed_sender_with_ack_retry_core.sv =====
// tb_framed_sender_with_ack_retry_core: self-checking bench for the framed sender core,
// predicts frame, resend and delivered words in a scoreboard class and checks each strobe
// depends on fsar_pkg and framed_sender_with_ack_retry_core
`default_nettype none

module tb_framed_sender_with_ack_retry_core;
  import fsar_pkg::*;

  localparam int          HALF_PERIOD   = 5;
  localparam int          PAYLOAD_DEPTH = 32;
  localparam int          WORD_TARGET   = 450;
  localparam int          SETTLE_CYCLES = 6;
  localparam int unsigned CYCLE_LIMIT   = 600000;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] tx_byte;
    logic              last;
    logic [BYTE_W-1:0] attempt;
  } tx_word_t;

  class frame_scoreboard;
    logic [BYTE_W-1:0] payload_mem [PAYLOAD_DEPTH];
    bit                waiting;
    logic [BYTE_W-1:0] timer;
    logic [BYTE_W-1:0] rx_latch;
    logic [BYTE_W-1:0] attempts;
    logic [LEN_W-1:0]  length_reg;
    logic [BYTE_W-1:0] timeout_reg;
    tx_word_t          expected_q [$];
    tx_word_t          item_q [$];
    int                errors;

    function new();
      foreach (payload_mem[i]) payload_mem[i] = '0;
      waiting     = 1'b0;
      timer       = '0;
      rx_latch    = '0;
      attempts    = '0;
      length_reg  = RESET_LENGTH;
      timeout_reg = RESET_TIMEOUT;
      errors      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
      if (idx == CFG_LENGTH) begin
        length_reg = data[LEN_W-1:0];
      end else begin
        timeout_reg = data;
      end
    endfunction

    function void emit(logic kind, logic [BYTE_W-1:0] b);
      tx_word_t w;
      w.kind    = kind;
      w.tx_byte = b;
      w.last    = 1'b0;
      w.attempt = attempts;
      item_q.push_back(w);
    endfunction

    function void send_frame();
      int unsigned       n;
      logic [BYTE_W-1:0] sum;
      n   = (length_reg > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : length_reg;
      sum = '0;
      if (attempts != BYTE_MAX) attempts++;
      emit(KIND_BYTE, BYTE_STX);
      emit(KIND_BYTE, BYTE_W'(n));
      for (int i = 0; i < n; i++) begin
        emit(KIND_BYTE, payload_mem[i]);
        sum ^= payload_mem[i];
      end
      emit(KIND_BYTE, sum);
      emit(KIND_BYTE, BYTE_ETX);
      timer   = '0;
      waiting = 1'b1;
    endfunction

    function void ack_check();
      if (waiting && rx_latch == BYTE_ACK) begin
        rx_latch = '0;
        waiting  = 1'b0;
        emit(KIND_DELIVERED, '0);
      end
    endfunction

    function void note_word(func_e f, logic [INDEX_W-1:0] idx, logic [BYTE_W-1:0] val);
      logic [BYTE_W-1:0] limit;
      limit = (timeout_reg == '0) ? BYTE_W'(1) : timeout_reg;
      item_q.delete();
      case (f)
        FUNC_LOAD: begin
          payload_mem[idx] = val;
        end
        FUNC_START: begin
          if (!waiting) begin
            send_frame();
            ack_check();
          end
        end
        FUNC_TICK: begin
          if (waiting) begin
            if (timer != BYTE_MAX) timer++;
            if (rx_latch == BYTE_ACK) ack_check();
            else if (timer >= limit) send_frame();
          end
        end
        default: begin
          rx_latch = val;
          ack_check();
        end
      endcase
      if (item_q.size() > 0) item_q[item_q.size()-1].last = 1'b1;
      foreach (item_q[i]) expected_q.push_back(item_q[i]);
    endfunction

    function void check_word(tx_word_t got);
      tx_word_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, got kind=%0d byte=%02h last=%0d attempt=%0d",
                 $time, got.kind, got.tx_byte, got.last, got.attempt);
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind || got.tx_byte !== want.tx_byte ||
          got.last !== want.last || got.attempt !== want.attempt) begin
        errors++;
        $display("%0t: word mismatch, expected kind=%0d byte=%02h last=%0d attempt=%0d",
                 $time, want.kind, want.tx_byte, want.last, want.attempt);
        $display("%0t:                got      kind=%0d byte=%02h last=%0d attempt=%0d",
                 $time, got.kind, got.tx_byte, got.last, got.attempt);
      end
    endfunction
  endclass

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 start_i     = 1'b0;
  logic [FUNC_W-1:0]    func_i      = FUNC_LOAD;
  logic [INDEX_W-1:0]   index_i     = '0;
  logic [BYTE_W-1:0]    value_i     = '0;
  logic                 cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_LENGTH;
  logic [BYTE_W-1:0]    cfg_data_i  = '0;
  logic                 busy_o;
  logic                 res_valid_o;
  logic                 kind_o;
  logic [BYTE_W-1:0]    tx_byte_o;
  logic                 last_o;
  logic [BYTE_W-1:0]    attempt_o;
  logic                 cfg_ready_o;

  frame_scoreboard sb;
  tx_word_t        seen_word;
  int unsigned     cycle_count = 0;
  int              word_count  = 0;
  bit              quiet       = 1'b0;

  framed_sender_with_ack_retry_core #(
    .MaxPayload(PAYLOAD_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .func_i     (func_i),
    .index_i    (index_i),
    .value_i    (value_i),
    .res_valid_o(res_valid_o),
    .kind_o     (kind_o),
    .tx_byte_o  (tx_byte_o),
    .last_o     (last_o),
    .attempt_o  (attempt_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o === 1'b1) begin
      seen_word.kind    = kind_o;
      seen_word.tx_byte = tx_byte_o;
      seen_word.last    = last_o;
      seen_word.attempt = attempt_o;
      sb.check_word(seen_word);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic push_word(func_e f, logic [INDEX_W-1:0] idx, logic [BYTE_W-1:0] val);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    func_i  <= f;
    index_i <= idx;
    value_i <= val;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    sb.note_word(f, idx, val);
    word_count++;
  endtask

  task automatic push_random(func_e f);
    push_word(f, INDEX_W'($urandom_range(0, PAYLOAD_DEPTH-1)), BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(logic [BYTE_W-1:0] len_data, logic [BYTE_W-1:0] to_data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_LENGTH;
    cfg_data_i  <= len_data;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    sb.write_reg(CFG_LENGTH, len_data);
    cfg_index_i <= CFG_TIMEOUT;
    cfg_data_i  <= to_data;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    sb.write_reg(CFG_TIMEOUT, to_data);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_exchange();
    int unsigned lim;
    int unsigned ticks;
    lim   = (sb.timeout_reg == '0) ? 1 : sb.timeout_reg;
    ticks = $urandom_range(0, (3 * lim < 16) ? 3 * lim : 16);
    repeat ($urandom_range(0, 2)) push_random(FUNC_LOAD);
    push_random(FUNC_START);
    repeat (ticks) begin
      if ($urandom_range(0, 7) == 0) begin
        push_random(FUNC_RX);
      end else begin
        push_random(FUNC_TICK);
      end
    end
    if ($urandom_range(0, 6) != 0) push_word(FUNC_RX, INDEX_W'($urandom_range(0, 31)), BYTE_ACK);
  endtask

  initial begin
    logic [BYTE_W-1:0] len_data;
    logic [BYTE_W-1:0] to_data;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // whole store written before any frame reads it
    for (int i = 0; i < PAYLOAD_DEPTH; i++) begin
      push_word(FUNC_LOAD, INDEX_W'(i),
                (i == 0) ? BYTE_W'(0) : (i == PAYLOAD_DEPTH-1) ? BYTE_MAX :
                BYTE_W'($urandom_range(0, 255)));
    end

    push_random(FUNC_TICK);
    push_random(FUNC_START);
    push_random(FUNC_START);
    push_word(FUNC_RX, '0, 8'h55);
    repeat (RESET_TIMEOUT) push_random(FUNC_TICK);
    push_word(FUNC_RX, '1, BYTE_ACK);
    push_word(FUNC_RX, '0, BYTE_ACK);
    push_random(FUNC_START);

    write_config('0, '0);
    push_random(FUNC_START);
    push_random(FUNC_TICK);
    push_word(FUNC_RX, '0, BYTE_ACK);

    write_config(BYTE_MAX, BYTE_MAX);
    push_random(FUNC_START);
    push_word(FUNC_RX, '0, BYTE_MAX);
    push_word(FUNC_RX, '0, BYTE_ACK);

    write_config(BYTE_W'(PAYLOAD_DEPTH), BYTE_W'(1));
    push_random(FUNC_START);
    push_random(FUNC_TICK);
    push_word(FUNC_RX, '0, BYTE_ACK);

    while (word_count < WORD_TARGET) begin
      case ($urandom_range(0, 11))
        0:       len_data = BYTE_W'(PAYLOAD_DEPTH);
        1:       len_data = BYTE_W'($urandom_range(0, 255));
        2:       len_data = BYTE_MAX;
        default: len_data = BYTE_W'($urandom_range(0, 6));
      endcase
      case ($urandom_range(0, 7))
        0:       to_data = '0;
        1:       to_data = BYTE_MAX;
        2:       to_data = BYTE_W'($urandom_range(0, 255));
        default: to_data = BYTE_W'($urandom_range(1, 4));
      endcase
      write_config(len_data, to_data);
      quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(3, 8)) begin
        if ($urandom_range(0, 4) == 0) begin
          push_random(func_e'($urandom_range(0, 3)));
        end else begin
          run_exchange();
        end
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
